// ===== design/tc_pkg.sv =====
// Package for the transitive closure block: transaction types, cell control, phase codes, column mask.
package tc_pkg;

	localparam int unsigned ROW_W   = 32;
	localparam int unsigned BIT_IDX = 5;
	localparam int unsigned NCNT_W  = 6;

	// Input transaction: one adjacency row
	typedef struct packed {
		logic [ROW_W-1:0] reach_row;
		logic             last_in;
	} adj_item_t;

	// Output transaction: one closed row
	typedef struct packed {
		logic [ROW_W-1:0] closure_row;
		logic             last_out;
	} res_item_t;

	// Per-cell control from the sequencer
	typedef struct packed {
		logic wr;     // capture the incoming row
		logic shift;  // take the neighbor's row
		logic tail;   // this cell closes the ring: take the wrapped head row
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		PH_LOAD,
		PH_CLOSE,
		PH_EMIT
	} phase_t;

	// Columns below n are kept
	function automatic logic [ROW_W-1:0] column_mask(input logic [NCNT_W-1:0] n);
		logic [ROW_W:0] ones;
		ones = (33'(1) << n) - 33'(1);
		if (n >= NCNT_W'(ROW_W)) begin
			return '1;
		end
		return ones[ROW_W-1:0];
	endfunction

endpackage

// ===== design/tc_cell.sv =====
// One cell of the row ring: holds a single matrix row.
module tc_cell (
	input  logic                       clk,
	input  tc_pkg::cell_ctrl_t         ctrl,
	input  logic [tc_pkg::ROW_W-1:0]   load_row,
	input  logic [tc_pkg::ROW_W-1:0]   next_row,
	input  logic [tc_pkg::ROW_W-1:0]   wrap_row,
	output logic [tc_pkg::ROW_W-1:0]   row
);

	logic [tc_pkg::ROW_W-1:0] row_q;

	// Load from the input, or move one place toward the head
	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			row_q <= load_row;
		end else if (ctrl.shift) begin
			row_q <= ctrl.tail ? wrap_row : next_row;
		end
	end

	assign row = row_q;

endmodule

// ===== design/transitive_closure.sv =====
// Top level of the transitive closure block: cell ring, sequencer and output register.
//
// Input channel adj (adj_valid / adj_stall / adj): one adjacency row per
// transaction, bit c set meaning an edge to node c; last_in ends the matrix.
// The number of rows taken sets the node count n (at most min(NODES, 32));
// later rows are dropped, but a dropped row with last_in still ends the matrix.
// Output channel clo (clo_valid / clo_stall / clo): the n closed rows in order,
// last_out on the final one. Columns at or beyond n read as zero.
// Rows sit in a ring of cells; the head row passes through one OR update per
// cycle and wraps to the tail cell; each pivot takes one full pass of the ring.
// Sequence: input rows are taken while loading, then one closure pass per
// pivot, then one row per cycle into the output register while clo is not stalled.
// adj_stall is high from the cycle after the last row until the last result
// has moved into the output register. A stall on clo holds the output
// register and pauses emission; no row is lost or repeated.
// Reset clears the phase, counters and valid flag; the row cells are not
// cleared, every row is written before it is read.
module transitive_closure #(
	parameter int unsigned NODES = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adj_valid,
	output logic              adj_stall,
	input  tc_pkg::adj_item_t adj,
	output logic              clo_valid,
	input  logic              clo_stall,
	output tc_pkg::res_item_t clo
);

	localparam int unsigned CAP = (NODES < tc_pkg::ROW_W) ? NODES : tc_pkg::ROW_W;
	localparam int unsigned IW  = $clog2(CAP);
	localparam int unsigned CW  = $clog2(CAP + 1);

	tc_pkg::phase_t phase_q, phase_nxt;

	logic [CW-1:0] rows_loaded_q;
	logic [CW-1:0] n_q;
	logic [IW-1:0] k_q;
	logic [IW-1:0] r_q;
	logic [tc_pkg::ROW_W-1:0] pivot_q;
	logic [tc_pkg::ROW_W-1:0] pivot_nxt_q;
	logic              clo_valid_q;
	tc_pkg::res_item_t clo_q;

	logic [tc_pkg::ROW_W-1:0] cell_row [CAP];
	logic [tc_pkg::ROW_W-1:0] head_row;
	logic [tc_pkg::ROW_W-1:0] upd_row;
	logic [tc_pkg::ROW_W-1:0] wrap_row;
	logic [tc_pkg::ROW_W-1:0] col_mask;

	logic adj_fire;
	logic store_row;
	logic emit_fire;
	logic pass_end;
	logic close_end;
	logic emit_end;
	logic ring_shift;
	logic pivot_hit;
	logic [CW-1:0] n_new;

	// Handshake and step conditions
	assign adj_fire  = adj_valid && !adj_stall;
	assign store_row = adj_fire && (rows_loaded_q < CW'(CAP));
	assign n_new     = store_row ? rows_loaded_q + CW'(1) : rows_loaded_q;
	assign emit_fire = (phase_q == tc_pkg::PH_EMIT) && (!clo_valid_q || !clo_stall);
	assign pass_end  = (CW'(r_q) + CW'(1)) == n_q;
	assign close_end = pass_end && ((CW'(k_q) + CW'(1)) == n_q);
	assign emit_end  = emit_fire && pass_end;
	assign ring_shift = (phase_q == tc_pkg::PH_CLOSE) || emit_fire;
	assign pivot_hit = (phase_q == tc_pkg::PH_CLOSE) && (CW'(r_q) == CW'(k_q) + CW'(1));

	// Head update: OR in the pivot row when the head row has an edge to the pivot node
	assign head_row = cell_row[0];
	assign upd_row  = head_row[tc_pkg::BIT_IDX'(k_q)] ? (head_row | pivot_q) : head_row;
	assign wrap_row = (phase_q == tc_pkg::PH_CLOSE) ? upd_row : head_row;
	assign col_mask = tc_pkg::column_mask(tc_pkg::NCNT_W'(n_q));

	// Ring of row cells
	for (genvar j = 0; j < CAP; j++) begin : g_cell
		tc_pkg::cell_ctrl_t       ctrl;
		logic [tc_pkg::ROW_W-1:0] next_row;

		assign ctrl.wr    = store_row && (rows_loaded_q == CW'(j));
		assign ctrl.shift = ring_shift;
		assign ctrl.tail  = (n_q == CW'(j + 1));

		if (j == CAP - 1) begin : g_end
			assign next_row = wrap_row;
		end else begin : g_mid
			assign next_row = cell_row[j + 1];
		end

		tc_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.load_row (adj.reach_row),
			.next_row (next_row),
			.wrap_row (wrap_row),
			.row      (cell_row[j])
		);
	end

	// Phase sequencer: next state
	always_comb begin
		phase_nxt = phase_q;
		unique case (phase_q)
			tc_pkg::PH_LOAD: begin
				if (adj_fire && adj.last_in) begin
					phase_nxt = tc_pkg::PH_CLOSE;
				end
			end
			tc_pkg::PH_CLOSE: begin
				if (close_end) begin
					phase_nxt = tc_pkg::PH_EMIT;
				end
			end
			tc_pkg::PH_EMIT: begin
				if (emit_end) begin
					phase_nxt = tc_pkg::PH_LOAD;
				end
			end
			default: phase_nxt = tc_pkg::PH_LOAD;
		endcase
	end

	// Phase sequencer: outputs
	always_comb begin
		adj_stall = 1'b1;
		unique case (phase_q)
			tc_pkg::PH_LOAD:  adj_stall = 1'b0;
			tc_pkg::PH_CLOSE: adj_stall = 1'b1;
			tc_pkg::PH_EMIT:  adj_stall = 1'b1;
			default:          adj_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tc_pkg::PH_LOAD;
		end else begin
			phase_q <= phase_nxt;
		end
	end

	// Row count, node count, pivot and head counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_loaded_q <= '0;
			n_q           <= '0;
			k_q           <= '0;
			r_q           <= '0;
		end else begin
			if (adj_fire) begin
				if (adj.last_in) begin
					rows_loaded_q <= '0;
					n_q           <= n_new;
					k_q           <= '0;
					r_q           <= '0;
				end else begin
					rows_loaded_q <= n_new;
				end
			end
			if (phase_q == tc_pkg::PH_CLOSE) begin
				if (pass_end) begin
					r_q <= '0;
					k_q <= close_end ? '0 : k_q + IW'(1);
				end else begin
					r_q <= r_q + IW'(1);
				end
			end
			if (emit_fire) begin
				r_q <= pass_end ? '0 : r_q + IW'(1);
			end
		end
	end

	// Next pivot: caught as it leaves the head during the current pass
	always_ff @(posedge clk) begin
		if (pivot_hit) begin
			pivot_nxt_q <= upd_row;
		end
	end

	// Pivot row: row 0 at load, then the next pivot at the end of each pass
	always_ff @(posedge clk) begin
		if (store_row && (rows_loaded_q == '0)) begin
			pivot_q <= adj.reach_row;
		end else if ((phase_q == tc_pkg::PH_CLOSE) && pass_end) begin
			pivot_q <= pivot_hit ? upd_row : pivot_nxt_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clo_valid_q <= 1'b0;
		end else if (emit_fire) begin
			clo_valid_q <= 1'b1;
		end else if (!clo_stall) begin
			clo_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			clo_q.closure_row <= head_row & col_mask;
			clo_q.last_out    <= pass_end;
		end
	end

	assign clo_valid = clo_valid_q;
	assign clo       = clo_q;

	// Checks
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		adj_valid && !adj_stall && adj.last_in |=> adj_stall)
		else $error("input not stalled after last row");

	a_load_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rows_loaded_q <= CW'(CAP))
		else $error("row count beyond capacity");

	a_close_idx: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == tc_pkg::PH_CLOSE |-> (CW'(r_q) < n_q) && (CW'(k_q) < n_q))
		else $error("closure index out of range");

	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(clo_valid) |-> $past(phase_q) == tc_pkg::PH_EMIT)
		else $error("result raised outside emission");

endmodule
